/* hdl/keyed_slot_table_macros.svh */
// assertion helpers for the keyed slot table
// every macro samples on clk and is switched off while arst_n is low
`ifndef KEYED_SLOT_TABLE_MACROS_SVH
`define KEYED_SLOT_TABLE_MACROS_SVH

// condition holds in the same cycle as the trigger
`define KST_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// condition holds in the cycle after the trigger
`define KST_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* hdl/kst_pkg.sv */
package kst_pkg;

	localparam int SLOTS_DEF       = 16;
	localparam int KEY_BITS_DEF    = 64;
	localparam int HANDLE_BITS_DEF = 16;

	// fixed field widths of the request, the response and the slots in use word
	localparam int KEY_W    = 64;
	localparam int HANDLE_W = 16;
	localparam int SIU_W    = 5;
	localparam logic [SIU_W-1:0] SIU_RESET = 5'd16;

	typedef enum logic [1:0] {
		KIND_INSERT  = 2'd0,
		KIND_LOOKUP  = 2'd1,
		KIND_DELETE  = 2'd2,
		KIND_COMPACT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		kind_t                kind;
		logic [KEY_W-1:0]     key;
		logic [HANDLE_W-1:0]  handle;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [HANDLE_W-1:0]  found_handle;
	} rsp_t;

	typedef enum logic [1:0] {
		SC_IDLE = 2'd0,
		SC_RUN  = 2'd1,
		SC_FIN  = 2'd2
	} scan_state_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic idle;
		logic done;
	} scan_stat_t;

endpackage

/* hdl/kst_ram.sv */
module kst_ram #(
	parameter int DEPTH = kst_pkg::SLOTS_DEF,
	parameter int WIDTH = kst_pkg::KEY_BITS_DEF + kst_pkg::HANDLE_BITS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* hdl/kst_scan.sv */
module kst_scan #(
	parameter int SLOTS       = kst_pkg::SLOTS_DEF,
	parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF,
	localparam int IDX_W  = $clog2(SLOTS),
	localparam int CNT_W  = $clog2(SLOTS + 1),
	localparam int WORD_W = KEY_BITS + HANDLE_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  kst_pkg::req_t       req,
	input  logic [CNT_W-1:0]    n,
	input  logic                rsp_ready,
	output kst_pkg::scan_stat_t stat,
	output kst_pkg::rsp_t       rsp,
	output logic                ram_we,
	output logic [IDX_W-1:0]    ram_waddr,
	output logic [WORD_W-1:0]   ram_wdata,
	output logic [IDX_W-1:0]    ram_raddr,
	input  logic [WORD_W-1:0]   ram_rdata
);

	// handle bits carried between the port field and the stored word
	localparam int HW_IN = (HANDLE_BITS < kst_pkg::HANDLE_W) ? HANDLE_BITS : kst_pkg::HANDLE_W;

	kst_pkg::scan_state_t state_q, state_d;
	kst_pkg::req_t        req_q;
	logic [IDX_W-1:0]     scan_idx_q, scan_idx_d;
	logic [IDX_W-1:0]     dst_q, dst_d;
	logic [IDX_W-1:0]     idx_s1;
	logic                 valid_s1;
	logic [SLOTS-1:0]     busy_q, busy_d;
	logic [CNT_W-1:0]     count_q, count_d;
	kst_pkg::rsp_t        res_q, res_d;

	logic [KEY_BITS-1:0]    key_q;
	logic [HANDLE_BITS-1:0] handle_in;
	logic [KEY_BITS-1:0]    rd_key;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   last;
	logic                   hit;

	assign key_q     = req_q.key[KEY_BITS-1:0];
	assign handle_in = HANDLE_BITS'(req_q.handle[HW_IN-1:0]);
	assign rd_key    = ram_rdata[WORD_W-1:HANDLE_BITS];
	assign rd_handle = ram_rdata[HANDLE_BITS-1:0];
	assign last      = (CNT_W'(idx_s1) + CNT_W'(1)) == n;
	assign hit       = busy_q[idx_s1] && (rd_key == key_q);

	assign ram_raddr = scan_idx_q;
	assign stat.idle = (state_q == kst_pkg::SC_IDLE);
	assign stat.done = (state_q == kst_pkg::SC_FIN);
	assign rsp       = res_q;

	always_comb begin
		state_d    = state_q;
		scan_idx_d = scan_idx_q;
		dst_d      = dst_q;
		busy_d     = busy_q;
		count_d    = count_q;
		res_d      = res_q;
		ram_we     = 1'b0;
		ram_waddr  = idx_s1;
		ram_wdata  = {key_q, handle_in};
		case (state_q)
			kst_pkg::SC_IDLE: begin
				if (start) begin
					scan_idx_d = '0;
					dst_d      = '0;
					res_d.found_handle = '0;
					res_d.status       = kst_pkg::ST_DONE;
					// nothing visible, or no room: answer without scanning
					if (n == '0 || (req.kind == kst_pkg::KIND_INSERT && count_q >= n)) begin
						state_d = kst_pkg::SC_FIN;
						case (req.kind)
							kst_pkg::KIND_INSERT: res_d.status = kst_pkg::ST_FULL;
							kst_pkg::KIND_LOOKUP: res_d.status = kst_pkg::ST_MISSING;
							kst_pkg::KIND_DELETE: res_d.status = kst_pkg::ST_MISSING;
							default:              res_d.status = kst_pkg::ST_DONE;
						endcase
					end else begin
						state_d = kst_pkg::SC_RUN;
					end
				end
			end
			kst_pkg::SC_RUN: begin
				scan_idx_d = scan_idx_q + IDX_W'(1);
				if (valid_s1) begin
					case (req_q.kind)
						kst_pkg::KIND_INSERT: begin
							if (!busy_q[idx_s1]) begin
								ram_we          = 1'b1;
								busy_d[idx_s1]  = 1'b1;
								count_d         = count_q + CNT_W'(1);
								res_d.status    = kst_pkg::ST_DONE;
								state_d         = kst_pkg::SC_FIN;
							end else if (last) begin
								res_d.status = kst_pkg::ST_FULL;
								state_d      = kst_pkg::SC_FIN;
							end
						end
						kst_pkg::KIND_LOOKUP: begin
							if (hit) begin
								res_d.status       = kst_pkg::ST_DONE;
								res_d.found_handle = kst_pkg::HANDLE_W'(rd_handle[HW_IN-1:0]);
								state_d            = kst_pkg::SC_FIN;
							end else if (last) begin
								res_d.status = kst_pkg::ST_MISSING;
								state_d      = kst_pkg::SC_FIN;
							end
						end
						kst_pkg::KIND_DELETE: begin
							if (hit) begin
								busy_d[idx_s1] = 1'b0;
								if (count_q != '0) begin
									count_d = count_q - CNT_W'(1);
								end
								res_d.status = kst_pkg::ST_DONE;
								state_d      = kst_pkg::SC_FIN;
							end else if (last) begin
								res_d.status = kst_pkg::ST_MISSING;
								state_d      = kst_pkg::SC_FIN;
							end
						end
						default: begin
							// compact: dst trails the read pointer, so no write hits a later read
							if (busy_q[idx_s1]) begin
								if (idx_s1 != dst_q) begin
									ram_we         = 1'b1;
									ram_waddr      = dst_q;
									ram_wdata      = ram_rdata;
									busy_d[dst_q]  = 1'b1;
									busy_d[idx_s1] = 1'b0;
								end
								dst_d = dst_q + IDX_W'(1);
							end
							if (last) begin
								res_d.status = kst_pkg::ST_DONE;
								state_d      = kst_pkg::SC_FIN;
							end
						end
					endcase
				end
			end
			kst_pkg::SC_FIN: begin
				if (rsp_ready) begin
					state_d = kst_pkg::SC_IDLE;
				end
			end
			default: begin
				state_d = kst_pkg::SC_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= kst_pkg::SC_IDLE;
			scan_idx_q <= '0;
			dst_q      <= '0;
			valid_s1   <= 1'b0;
			busy_q     <= '0;
			count_q    <= '0;
		end else begin
			state_q    <= state_d;
			scan_idx_q <= scan_idx_d;
			dst_q      <= dst_d;
			valid_s1   <= (state_q == kst_pkg::SC_RUN);
			busy_q     <= busy_d;
			count_q    <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.idle && start) begin
			req_q <= req;
		end
		idx_s1 <= scan_idx_q;
		res_q  <= res_d;
	end

endmodule

/* hdl/keyed_slot_table.sv */
// channel   | signals                      | direction | moves
// ----------+------------------------------+-----------+-------------------------------
// request   | in_valid, in_ready, in_req   | in        | kind, key, handle
// response  | out_valid, out_ready, out_rsp| out       | status, found_handle
// config    | cfg_we, cfg_wdata            | in        | slots_in_use, written at once
//
// a request that needs no scan (no visible slot, or insert with the entry count at or above
// the visible slots) is answered without scanning; otherwise the scan stops at the slot that
// ends it, and compact always scans every visible slot
// the key/handle memory has one read port and is read one slot per cycle during a scan
// busy flags and the entry count sit in flops and clear at reset, so no clearing pass runs
// a response waiting in the output register does not block the next request
`include "keyed_slot_table_macros.svh"

module keyed_slot_table #(
	parameter int SLOTS       = kst_pkg::SLOTS_DEF,
	parameter int KEY_BITS    = kst_pkg::KEY_BITS_DEF,
	parameter int HANDLE_BITS = kst_pkg::HANDLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  kst_pkg::req_t              in_req,
	output logic                       out_valid,
	input  logic                       out_ready,
	output kst_pkg::rsp_t              out_rsp,
	input  logic                       cfg_we,
	input  logic [kst_pkg::SIU_W-1:0]  cfg_wdata
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int WORD_W = KEY_BITS + HANDLE_BITS;

	// slots in use register
	logic [kst_pkg::SIU_W-1:0] siu_q;
	// visible slots: register clamped to the built capacity
	logic [CNT_W-1:0]          n_vis;

	kst_pkg::scan_stat_t stat;
	kst_pkg::rsp_t       scan_rsp;
	logic                rsp_ready;
	logic                out_valid_q;
	kst_pkg::rsp_t       out_rsp_q;

	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [IDX_W-1:0]    ram_raddr;
	logic [WORD_W-1:0]   ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			siu_q <= kst_pkg::SIU_RESET;
		end else if (cfg_we) begin
			siu_q <= cfg_wdata;
		end
	end

	assign n_vis = (int'(siu_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(siu_q);

	// a new request is taken whenever the sequencer is idle
	assign in_ready  = stat.idle;
	// the sequencer hands over its result once the output register is free or draining
	assign rsp_ready = !out_valid_q || out_ready;

	kst_scan #(
		.SLOTS       (SLOTS),
		.KEY_BITS    (KEY_BITS),
		.HANDLE_BITS (HANDLE_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.req       (in_req),
		.n         (n_vis),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.rsp       (scan_rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// key and handle of every slot, one word per slot
	kst_ram #(
		.DEPTH (SLOTS),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done && rsp_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && rsp_ready) begin
			out_rsp_q <= scan_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rsp   = out_rsp_q;

	// after an accepted request the sequencer is busy in the next cycle
	`KST_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request accepted while sequencer stayed idle")
	// a handed over result always lands in the output register
	`KST_ASSERT_NEXT(a_result_lands, stat.done && rsp_ready, out_valid, "finished result was lost")
	// only a successful lookup carries a handle
	`KST_ASSERT_SAME(a_handle_zero, out_valid && out_rsp.status != kst_pkg::ST_DONE, out_rsp.found_handle == '0, "handle given with a failing status")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

	localparam int TBL_SLOTS = kst_pkg::SLOTS_DEF;
	localparam int POOL_N = 12;

	// clock, reset and the block's ports
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	kst_pkg::req_t in_req = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	kst_pkg::rsp_t out_rsp;
	logic cfg_we = 1'b0;
	logic [kst_pkg::SIU_W-1:0] cfg_wdata = '0;

	keyed_slot_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_rsp   (out_rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// shadow copy of the table: busy flags, keys, handles, occupancy, slots in use
	logic                          slot_taken [TBL_SLOTS];
	logic [kst_pkg::KEY_W-1:0]     slot_key   [TBL_SLOTS];
	logic [kst_pkg::HANDLE_W-1:0]  slot_ref   [TBL_SLOTS];
	int                            taken_count = 0;
	logic [kst_pkg::SIU_W-1:0]     visible_cfg = kst_pkg::SIU_RESET;

	// requests waiting to be offered, and responses the table owes us
	kst_pkg::req_t req_backlog [$];
	kst_pkg::rsp_t table_answers [$];

	// bookkeeping
	int req_sent = 0;
	int rsp_seen = 0;
	int fail_count = 0;
	int cfg_writes = 0;
	int kind_seen [4] = '{0, 0, 0, 0};
	int status_seen [4] = '{0, 0, 0, 0};
	logic [kst_pkg::KEY_W-1:0] key_pool [POOL_N];

	initial begin
		for (int i = 0; i < TBL_SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_key[i] = '0;
			slot_ref[i] = '0;
		end
	end

	// lowest visible busy slot holding the key, vis when there is none
	function automatic int lowest_match(logic [kst_pkg::KEY_W-1:0] k, int vis);
		int hit;
		hit = vis;
		for (int i = vis - 1; i >= 0; i--)
			if (slot_taken[i] && slot_key[i] == k)
				hit = i;
		return hit;
	endfunction

	// apply one request to the shadow table and return the response it owes
	function automatic kst_pkg::rsp_t table_apply(kst_pkg::req_t r);
		kst_pkg::rsp_t ans;
		int vis;
		int hit;
		int dst;
		logic placed;
		// settings above the built size only expose the built size
		vis = (visible_cfg > TBL_SLOTS) ? TBL_SLOTS : int'(visible_cfg);
		ans.status = kst_pkg::ST_DONE;
		ans.found_handle = '0;
		case (r.kind)
			kst_pkg::KIND_INSERT: begin
				// full when the count has caught up, or when no visible slot is free
				ans.status = kst_pkg::ST_FULL;
				placed = 1'b0;
				if (taken_count < vis)
					for (int i = 0; i < vis; i++)
						if (!placed && !slot_taken[i]) begin
							slot_key[i] = r.key;
							slot_ref[i] = r.handle;
							slot_taken[i] = 1'b1;
							taken_count++;
							placed = 1'b1;
							ans.status = kst_pkg::ST_DONE;
						end
			end
			kst_pkg::KIND_LOOKUP: begin
				hit = lowest_match(r.key, vis);
				if (hit < vis)
					ans.found_handle = slot_ref[hit];
				else
					ans.status = kst_pkg::ST_MISSING;
			end
			kst_pkg::KIND_DELETE: begin
				hit = lowest_match(r.key, vis);
				if (hit < vis) begin
					slot_taken[hit] = 1'b0;
					if (taken_count > 0)
						taken_count--;
				end else
					ans.status = kst_pkg::ST_MISSING;
			end
			default: begin
				// slide busy entries down, order kept; hidden slots stay put
				dst = 0;
				for (int src = 0; src < vis; src++)
					if (slot_taken[src]) begin
						if (src != dst) begin
							slot_key[dst] = slot_key[src];
							slot_ref[dst] = slot_ref[src];
							slot_taken[dst] = 1'b1;
							slot_taken[src] = 1'b0;
						end
						dst++;
					end
			end
		endcase
		return ans;
	endfunction

	// text-like key: printable characters from the top byte down, zeros after
	function automatic logic [kst_pkg::KEY_W-1:0] text_key();
		logic [kst_pkg::KEY_W-1:0] k;
		int n;
		k = '0;
		n = $urandom_range(1, 8);
		for (int i = 0; i < n; i++)
			k[kst_pkg::KEY_W-1-8*i -: 8] = 8'($urandom_range(32, 126));
		return k;
	endfunction

	// random request; mostly keys from the pool so lookups and deletes hit
	function automatic kst_pkg::req_t random_req();
		kst_pkg::req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			r.kind = kst_pkg::KIND_INSERT;
		else if (pick < 65)
			r.kind = kst_pkg::KIND_LOOKUP;
		else if (pick < 90)
			r.kind = kst_pkg::KIND_DELETE;
		else
			r.kind = kst_pkg::KIND_COMPACT;
		pick = $urandom_range(99);
		if (pick < 75)
			r.key = key_pool[$urandom_range(POOL_N - 1)];
		else if (pick < 90)
			r.key = {$urandom, $urandom};
		else
			r.key = text_key();
		r.handle = kst_pkg::HANDLE_W'($urandom_range(16'hFFFF));
		return r;
	endfunction

	task automatic queue_req(kst_pkg::kind_t k, logic [kst_pkg::KEY_W-1:0] key,
			logic [kst_pkg::HANDLE_W-1:0] h);
		kst_pkg::req_t r;
		r.kind = k;
		r.key = key;
		r.handle = h;
		req_backlog.push_back(r);
	endtask

	// hold the stimulus until every queued request has been answered
	task automatic wait_drained();
		@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || table_answers.size() != 0)
			@(negedge clk);
	endtask

	// table is idle here, so the new size applies to the next request
	task automatic set_slots_in_use(logic [kst_pkg::SIU_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		visible_cfg = v;
		cfg_writes++;
	endtask

	// one stretch of full-rate traffic on each side, otherwise ~37% idle cycles
	wire send_calm = (req_sent >= 500 && req_sent < 650);
	wire take_calm = (rsp_seen >= 500 && rsp_seen < 650);

	// request driver: keeps valid and payload steady until the handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_req <= '0;
		end else if (!in_valid || in_ready) begin
			if (req_backlog.size() != 0 && (send_calm || $urandom_range(99) >= 37)) begin
				in_req <= req_backlog.pop_front();
				in_valid <= 1'b1;
			end else
				in_valid <= 1'b0;
		end
	end

	// response side ready, with one long hold-off so the table backs up
	int stall_left = 0;
	logic stall_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else if (stall_left != 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!stall_done && rsp_seen >= 350) begin
			out_ready <= 1'b0;
			stall_left <= 80;
			stall_done <= 1'b1;
		end else
			out_ready <= take_calm || ($urandom_range(99) >= 37);
	end

	// watch both channels: check responses first, then predict the new request
	always @(posedge clk) begin : watch
		kst_pkg::rsp_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				rsp_seen <= rsp_seen + 1;
				status_seen[out_rsp.status]++;
				if (table_answers.size() == 0) begin
					$display("%0t: response with nothing owed: status %0d handle %h",
						$time, out_rsp.status, out_rsp.found_handle);
					fail_count++;
				end else begin
					want = table_answers.pop_front();
					if (out_rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, out_rsp.status);
						fail_count++;
					end
					if (out_rsp.found_handle !== want.found_handle) begin
						$display("%0t: found_handle expected %h actual %h",
							$time, want.found_handle, out_rsp.found_handle);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				req_sent <= req_sent + 1;
				kind_seen[in_req.kind]++;
				table_answers.push_back(table_apply(in_req));
			end
		end
	end

	// stimulus: directed opening, then random phases under varied table sizes
	initial begin : stimulus
		logic [kst_pkg::SIU_W-1:0] sizes [9];
		logic [kst_pkg::KEY_W-1:0] word_key;
		logic [kst_pkg::KEY_W-1:0] odd_key;
		sizes = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd20, 5'd2, 5'd8, 5'd16};
		word_key = 64'h6B65_7900_0000_0000;
		odd_key = {$urandom, $urandom};
		key_pool[0] = '0;
		key_pool[1] = '1;
		key_pool[2] = 64'h5555_5555_5555_5555;
		key_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
		wait (arst_n === 1'b1);
		@(negedge clk);

		// empty table at the reset size: misses, empty compact, duplicates
		queue_req(kst_pkg::KIND_LOOKUP, '0, 16'h1111);
		queue_req(kst_pkg::KIND_DELETE, '0, 16'h2222);
		queue_req(kst_pkg::KIND_COMPACT, '1, 16'hFFFF);
		queue_req(kst_pkg::KIND_INSERT, '0, 16'h0000);
		queue_req(kst_pkg::KIND_INSERT, '1, 16'hFFFF);
		queue_req(kst_pkg::KIND_INSERT, '0, 16'h1234);
		queue_req(kst_pkg::KIND_LOOKUP, '0, 16'h0000);
		queue_req(kst_pkg::KIND_LOOKUP, '1, 16'h0000);
		queue_req(kst_pkg::KIND_DELETE, '0, 16'h0000);
		queue_req(kst_pkg::KIND_LOOKUP, '0, 16'h0000);
		queue_req(kst_pkg::KIND_INSERT, word_key, 16'h0001);
		queue_req(kst_pkg::KIND_COMPACT, '0, 16'h0000);
		queue_req(kst_pkg::KIND_LOOKUP, word_key, 16'h0000);
		queue_req(kst_pkg::KIND_LOOKUP, odd_key, 16'h0000);
		wait_drained();

		// two visible slots: full by the entry count, entries above hidden
		set_slots_in_use(5'd2);
		@(negedge clk);
		queue_req(kst_pkg::KIND_INSERT, odd_key, 16'h8001);
		queue_req(kst_pkg::KIND_INSERT, 64'h5555_5555_5555_5555, 16'h7FFE);
		queue_req(kst_pkg::KIND_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 16'h00FF);
		queue_req(kst_pkg::KIND_LOOKUP, word_key, 16'h0000);
		queue_req(kst_pkg::KIND_DELETE, '1, 16'h0000);
		queue_req(kst_pkg::KIND_COMPACT, '0, 16'h0000);
		wait_drained();

		// no visible slot at all
		set_slots_in_use(5'd0);
		@(negedge clk);
		queue_req(kst_pkg::KIND_INSERT, '0, 16'hFFFF);
		queue_req(kst_pkg::KIND_LOOKUP, '1, 16'h0000);
		queue_req(kst_pkg::KIND_DELETE, '1, 16'h0000);
		queue_req(kst_pkg::KIND_COMPACT, '0, 16'h0000);
		wait_drained();

		// random phases, each after a drained table and a new size
		foreach (sizes[p]) begin
			set_slots_in_use(sizes[p]);
			for (int i = 4; i < POOL_N; i++)
				key_pool[i] = (i % 2 == 0) ? text_key() : {$urandom, $urandom};
			@(negedge clk);
			for (int i = 0; i < 100; i++)
				req_backlog.push_back(random_req());
			wait_drained();
		end

		// let anything stray come out before judging
		repeat (40) @(posedge clk);
		$display("covered %0d requests (insert %0d, lookup %0d, delete %0d, compact %0d)",
			req_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("answers: done %0d, full %0d, not found %0d; %0d table size changes",
			status_seen[0], status_seen[1], status_seen[2], cfg_writes);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin
		#2000000;
		$display("timeout with %0d responses still owed", table_answers.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/kst_pkg.sv
hdl/kst_ram.sv
hdl/kst_scan.sv
hdl/keyed_slot_table.sv
tb/tb_top.sv
